// ===== hw/rtl/pmb_pkg.sv =====
// pmb_pkg: shared constants and the sequencer state type for profile_mismatch_base.
// No dependencies.
`timescale 1ns / 1ps
package pmb_pkg;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_WIDTH  = 4096;
  localparam int SLAB_DEPTH = MAX_ROWS * MAX_WIDTH;
  localparam int SLAB_AW    = $clog2(SLAB_DEPTH);
  localparam int COL_AW     = $clog2(MAX_WIDTH);
  localparam int SUM_W      = 22;
  localparam int PROD_W     = 38;
  localparam int ACC_W      = 51;
  localparam int NUM_W      = 36;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_SITES  = 2'd1;
  localparam logic [1:0] REG_STATES = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_LOAD, ST_LWR, ST_RUN, ST_DRAIN, ST_DIV, ST_FIN, ST_EMIT
  } pmb_state_t;
endpackage

// ===== hw/rtl/pmb_ram.sv =====
// pmb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module pmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hw/rtl/profile_mismatch_base.sv =====
// profile_mismatch_base: slab loader, column sums and per-row mismatch base.
// Uses pmb_pkg and pmb_ram (slab store and column sum memories).
//
// Usage: write row_count / site_count / state_count on the cfg channel
// (index 0/1/2, any write restarts the load). Stream profile values on
// in_* in row-major order (row, site, state); each request passes through
// a load and a write-back state (column sum read-modify-write in one
// memory). After the final value the block walks the stored slab: per
// row, a multiply-accumulate pass through one multiplier, the bit-serial
// divider and a step to form the result, then it waits for out_tready.
// After the last row the column sums are swept to zero before in_tready
// rises again. If sites*states exceeds 4096, each input request emits
// every row in turn with mismatch 0 and overflow set; nothing is stored.
// Reset: registers return to 1/1/4, a clearing pass over all 4096
// column sums runs with in_tready low; cfg writes are accepted throughout.
// A stalled receiver holds the result in the output register; the
// sequencer waits there, nothing is dropped.
`timescale 1ns / 1ps
module profile_mismatch_base
  import pmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] profile_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] row_index, [37:6] mismatch_base, [39:38] zero
  output logic        out_tuser,  // [0] overflow
  output logic        out_tlast   // last_row
);
  pmb_state_t state_r, state_nxt;

  logic [6:0]  rows_cfg_r, states_cfg_r;
  logic [12:0] sites_cfg_r;
  logic [COL_AW-1:0]  clr_r, clr_nxt, coord_r, coord_nxt, c_r, c_nxt;
  logic [5:0]  lrow_r, lrow_nxt, crow_r, crow_nxt;
  logic [SLAB_AW-1:0] pos_r, pos_nxt, base_r, base_nxt;
  logic [15:0] v_r, v_nxt;
  logic        rdv_r, prodv_r, ovfmode_r, ovfmode_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic [5:0]  out_row_r, out_row_nxt;
  logic [31:0] out_mb_r, out_mb_nxt;
  logic        out_ovf_r, out_ovf_nxt, out_last_r, out_last_nxt;

  logic [6:0]  rows_eff, states_eff;
  logic [5:0]  rows_m1;
  logic [12:0] sites_eff;
  logic [19:0] width;
  logic        too_wide;
  logic [COL_AW-1:0] wm1;
  logic        cfg_hit, in_acc, out_acc;

  logic        slab_we, col_we;
  logic [SLAB_AW-1:0] slab_raddr;
  logic [COL_AW-1:0]  col_waddr, col_raddr;
  logic [SUM_W-1:0]   col_wdata, col_q;
  logic [15:0]        slab_q;
  logic [SUM_W-1:0]   diff;
  logic [ACC_W:0]     num_sum;
  logic [13:0]        trial;
  logic signed [37:0] res;

  localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

  assign rows_eff   = (rows_cfg_r == 7'd0) ? 7'd1 :
                      (rows_cfg_r > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_cfg_r;
  assign rows_m1    = 6'(rows_eff - 7'd1);
  assign sites_eff  = (sites_cfg_r == 13'd0) ? 13'd1 : sites_cfg_r;
  assign states_eff = (states_cfg_r == 7'd0) ? 7'd1 :
                      (states_cfg_r > 7'd64) ? 7'd64 : states_cfg_r;
  assign width      = 20'(sites_eff) * 20'(states_eff);
  assign too_wide   = width > 20'(MAX_WIDTH);
  assign wm1        = COL_AW'(width - 20'd1);

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_ROWS || cfg_index == REG_SITES ||
                                   cfg_index == REG_STATES);
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_acc   = out_tvalid && out_tready;
  assign out_tdata = {2'b00, out_mb_r, out_row_r};
  assign out_tuser = out_ovf_r;
  assign out_tlast = out_last_r;

  pmb_ram #(.WIDTH(16), .DEPTH(SLAB_DEPTH)) u_slab (
    .clk(clk), .we(slab_we), .waddr(pos_r), .wdata(in_tdata),
    .raddr(slab_raddr), .rdata(slab_q)
  );

  pmb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_colsum (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_q)
  );

  assign slab_we    = in_acc && !too_wide;
  assign slab_raddr = SLAB_AW'(base_r + SLAB_AW'(c_r));
  assign col_raddr  = (state_r == ST_RUN) ? c_r : coord_r;
  assign col_we     = (state_r == ST_CLEAR) || (state_r == ST_LWR);
  assign col_waddr  = (state_r == ST_CLEAR) ? clr_r : coord_r;
  assign col_wdata  = (state_r == ST_CLEAR) ? '0 : SUM_W'(col_q + SUM_W'(v_r));

  assign diff    = col_q - SUM_W'(slab_q);
  assign num_sum = (ACC_W+1)'(acc_r) + ((ACC_W+1)'(sites_eff) << 15);
  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign res     = $signed({16'b0, rows_m1, 16'b0}) - $signed({2'b00, num_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == COL_AW'(MAX_WIDTH - 1)) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (in_acc) state_nxt = too_wide ? ST_FIN : ST_LWR;
      end
      ST_LWR: begin
        if (coord_r == wm1 && lrow_r == rows_m1) state_nxt = ST_RUN;
        else state_nxt = ST_LOAD;
      end
      ST_RUN:   if (c_r == wm1) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!rdv_r && !prodv_r) state_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == 6'(NUM_W - 1)) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) begin
          if (ovfmode_r) state_nxt = out_last_r ? ST_LOAD : ST_FIN;
          else state_nxt = out_last_r ? ST_CLEAR : ST_RUN;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    if (cfg_hit) state_nxt = ST_CLEAR;
  end

  // datapath updates
  always_comb begin
    clr_nxt = clr_r; coord_nxt = coord_r; lrow_nxt = lrow_r; pos_nxt = pos_r;
    v_nxt = v_r; c_nxt = c_r; crow_nxt = crow_r; base_nxt = base_r;
    acc_nxt = acc_r; num_nxt = num_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r;
    ovfmode_nxt = ovfmode_r;
    out_row_nxt = out_row_r; out_mb_nxt = out_mb_r;
    out_ovf_nxt = out_ovf_r; out_last_nxt = out_last_r;
    if (prodv_r) acc_nxt = acc_r + ACC_W'(prod_r);
    case (state_r)
      ST_CLEAR: clr_nxt = COL_AW'(clr_r + 1'b1);
      ST_LOAD: begin
        v_nxt = in_tdata;
        if (in_acc && too_wide) begin
          ovfmode_nxt = 1'b1;
          crow_nxt = '0;
        end
      end
      ST_LWR: begin
        pos_nxt = SLAB_AW'(pos_r + 1'b1);
        if (coord_r == wm1) begin
          coord_nxt = '0;
          lrow_nxt = 6'(lrow_r + 1'b1);
        end else begin
          coord_nxt = COL_AW'(coord_r + 1'b1);
        end
        if (coord_r == wm1 && lrow_r == rows_m1) begin
          c_nxt = '0; crow_nxt = '0; base_nxt = '0; acc_nxt = '0;
        end
      end
      ST_RUN: c_nxt = COL_AW'(c_r + 1'b1);
      ST_DRAIN: begin
        num_nxt = num_sum[ACC_W:16];
        rem_nxt = '0;
        dcnt_nxt = '0;
      end
      ST_DIV: begin
        dcnt_nxt = 6'(dcnt_r + 1'b1);
        if (trial >= {1'b0, sites_eff}) begin
          rem_nxt = 13'(trial - {1'b0, sites_eff});
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[12:0];
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
      end
      ST_FIN: begin
        out_row_nxt = crow_r;
        out_last_nxt = (crow_r == rows_m1);
        if (ovfmode_r) begin
          out_mb_nxt = '0;
          out_ovf_nxt = 1'b1;
        end else if (res < SAT_LO) begin
          out_mb_nxt = 32'h8000_0000;
          out_ovf_nxt = 1'b1;
        end else begin
          out_mb_nxt = res[31:0];
          out_ovf_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          crow_nxt = 6'(crow_r + 1'b1);
          c_nxt = '0;
          acc_nxt = '0;
          base_nxt = SLAB_AW'(base_r + SLAB_AW'(width));
          if (out_last_r) begin
            ovfmode_nxt = 1'b0;
            clr_nxt = '0; coord_nxt = '0; lrow_nxt = '0; pos_nxt = '0;
          end
        end
      end
      default: ;
    endcase
    if (cfg_hit) begin
      clr_nxt = '0; coord_nxt = '0; lrow_nxt = '0; pos_nxt = '0;
      ovfmode_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      rows_cfg_r <= 7'd1; sites_cfg_r <= 13'd1; states_cfg_r <= 7'd4;
      clr_r <= '0; coord_r <= '0; lrow_r <= '0; pos_r <= '0;
      c_r <= '0; crow_r <= '0; base_r <= '0; dcnt_r <= '0;
      rdv_r <= 1'b0; prodv_r <= 1'b0; ovfmode_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_index == REG_ROWS) rows_cfg_r <= cfg_data[6:0];
      if (cfg_valid && cfg_index == REG_SITES) sites_cfg_r <= cfg_data;
      if (cfg_valid && cfg_index == REG_STATES) states_cfg_r <= cfg_data[6:0];
      clr_r <= clr_nxt; coord_r <= coord_nxt; lrow_r <= lrow_nxt; pos_r <= pos_nxt;
      c_r <= c_nxt; crow_r <= crow_nxt; base_r <= base_nxt; dcnt_r <= dcnt_nxt;
      rdv_r <= (state_r == ST_RUN);
      prodv_r <= rdv_r;
      ovfmode_r <= ovfmode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    prod_r <= (col_q >= SUM_W'(slab_q)) ? PROD_W'(slab_q) * PROD_W'(diff) : '0;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    out_row_r <= out_row_nxt;
    out_mb_r <= out_mb_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end
endmodule
